FILE: rtl/memory_lcd_update_framer_macros.svh
// ----------------------------------------------------------------------------
// memory lcd update framer assertion macros
// shared concurrent assertion forms, clocked on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef MEMORY_LCD_UPDATE_FRAMER_MACROS_SVH
`define MEMORY_LCD_UPDATE_FRAMER_MACROS_SVH

// same-cycle implication
`define MLF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("framer assertion failed");

// next-cycle implication
`define MLF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("framer assertion failed");

`endif

FILE: rtl/mlf_pkg.sv
// ----------------------------------------------------------------------------
// mlf_pkg
// constants, types and helpers shared by the memory lcd update framer
// ----------------------------------------------------------------------------
package mlf_pkg;

	localparam int LINES          = 128;
	localparam int BYTES_PER_LINE = 48;

	// single-byte lines put mode, address, data and two trailer bytes in one go
	localparam int MAX_RESULTS = (BYTES_PER_LINE == 1) ? 5 : 3;
	localparam int IDX_W       = $clog2(MAX_RESULTS);
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] REQ_DATA     = 2'd0;
	localparam logic [1:0] REQ_CLEAR    = 2'd1;
	localparam logic [1:0] REQ_MAINTAIN = 2'd2;

	localparam logic [7:0] MODE_WRITE    = 8'h01;
	localparam logic [7:0] MODE_CLEAR    = 8'h04;
	localparam logic [7:0] MODE_MAINTAIN = 8'h00;

	// words caused by one request, in send order
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [MAX_RESULTS-1:0]      ends;
		logic [CNT_W-1:0]            count;
	} word_list_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int k = 0; k < 8; k++) begin
			r[k] = v[7-k];
		end
		return r;
	endfunction

endpackage

FILE: rtl/mlf_req_if.sv
// ----------------------------------------------------------------------------
// mlf_req_if
// request channel: one frame data byte or one command per word
// ----------------------------------------------------------------------------
interface mlf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] pixel_byte;

	modport source(output valid, output req_type, output pixel_byte, input ready);
	modport sink(input valid, input req_type, input pixel_byte, output ready);
endinterface

FILE: rtl/mlf_spi_if.sv
// ----------------------------------------------------------------------------
// mlf_spi_if
// serial byte channel: one wire-order byte per word
// ----------------------------------------------------------------------------
interface mlf_spi_if;
	logic       valid;
	logic       ready;
	logic [7:0] spi_byte;
	logic       transfer_end;
	logic       last;

	modport source(output valid, output spi_byte, output transfer_end, output last,
		input ready);
	modport sink(input valid, input spi_byte, input transfer_end, input last,
		output ready);
endinterface

FILE: rtl/mlf_framer.sv
// ----------------------------------------------------------------------------
// mlf_framer
// frame position and vcom state, builds the word list for one request
// ----------------------------------------------------------------------------
module mlf_framer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [1:0]           req_type,
	input  logic [7:0]           pixel_byte,
	output mlf_pkg::word_list_t  list
);

	logic       vcom_q;
	logic [7:0] line_q;
	logic [5:0] bil_q;

	logic       vcom_d;
	logic [7:0] line_d;
	logic [5:0] bil_d;
	logic       vcom_t;
	logic [6:0] bil_inc;
	logic [8:0] line_inc;
	logic [mlf_pkg::CNT_W-1:0] n;

	always_comb begin
		vcom_d   = vcom_q;
		line_d   = line_q;
		bil_d    = bil_q;
		vcom_t   = ~vcom_q;
		bil_inc  = {1'b0, bil_q} + 7'd1;
		line_inc = {1'b0, line_q} + 9'd1;
		n        = '0;
		list     = '0;
		case (req_type)
			mlf_pkg::REQ_DATA: begin
				if (line_q == 8'd0 && bil_q == 6'd0) begin
					vcom_d = vcom_t;
				end
				if (bil_q == 6'd0) begin
					list.bytes[n[mlf_pkg::IDX_W-1:0]] =
						mlf_pkg::rev8(mlf_pkg::MODE_WRITE | {6'd0, vcom_d, 1'b0});
					n = n + 1'b1;
					list.bytes[n[mlf_pkg::IDX_W-1:0]] = mlf_pkg::rev8(line_inc[7:0]);
					n = n + 1'b1;
				end
				list.bytes[n[mlf_pkg::IDX_W-1:0]] = mlf_pkg::rev8(pixel_byte);
				n     = n + 1'b1;
				bil_d = bil_inc[5:0];
				if (bil_inc >= 7'(mlf_pkg::BYTES_PER_LINE)) begin
					bil_d  = 6'd0;
					line_d = line_inc[7:0];
					if (line_inc >= 9'(mlf_pkg::LINES)) begin
						line_d = 8'd0;
						// two zero trailer bytes, select released after the second
						list.bytes[n[mlf_pkg::IDX_W-1:0]] = 8'h00;
						n = n + 1'b1;
						list.bytes[n[mlf_pkg::IDX_W-1:0]] = 8'h00;
						list.ends[n[mlf_pkg::IDX_W-1:0]]  = 1'b1;
						n = n + 1'b1;
					end
				end
			end
			mlf_pkg::REQ_CLEAR, mlf_pkg::REQ_MAINTAIN: begin
				vcom_d   = vcom_t;
				line_d   = 8'd0;
				bil_d    = 6'd0;
				list.bytes[0] = mlf_pkg::rev8(((req_type == mlf_pkg::REQ_CLEAR) ?
					mlf_pkg::MODE_CLEAR : mlf_pkg::MODE_MAINTAIN) | {6'd0, vcom_t, 1'b0});
				list.bytes[1] = 8'h00;
				list.ends[1]  = 1'b1;
				n = mlf_pkg::CNT_W'(2);
			end
			default: begin
				// unused request code: no words, state kept
			end
		endcase
		list.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcom_q <= 1'b0;
			line_q <= 8'd0;
			bil_q  <= 6'd0;
		end else if (take) begin
			vcom_q <= vcom_d;
			line_q <= line_d;
			bil_q  <= bil_d;
		end
	end

endmodule

FILE: rtl/mlf_drain.sv
// ----------------------------------------------------------------------------
// mlf_drain
// holds one word list and hands its bytes to the serial channel in order
// ----------------------------------------------------------------------------
`include "memory_lcd_update_framer_macros.svh"

module mlf_drain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  mlf_pkg::word_list_t list,
	output logic                can_take,
	mlf_spi_if.source           spi
);

	mlf_pkg::word_list_t        list_s1;
	logic                       valid_q;
	logic [mlf_pkg::IDX_W-1:0]  idx_q;
	logic                       at_last;
	logic                       out_take;

	assign at_last  = (mlf_pkg::CNT_W'(idx_q) + 1'b1) == list_s1.count;
	assign out_take = valid_q && spi.ready;
	assign can_take = !valid_q || (out_take && at_last);

	assign spi.valid        = valid_q;
	assign spi.spi_byte     = list_s1.bytes[idx_q];
	assign spi.transfer_end = list_s1.ends[idx_q];
	assign spi.last         = at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (can_take) begin
			valid_q <= load;
			idx_q   <= '0;
		end else if (out_take) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load) begin
			list_s1 <= list;
		end
	end

	`MLF_ASSERT_NOW(a_count_nonzero, valid_q, list_s1.count != '0)
	`MLF_ASSERT_NOW(a_idx_in_list, valid_q, mlf_pkg::CNT_W'(idx_q) < list_s1.count)
	`MLF_ASSERT_NEXT(a_mid_list_holds, out_take && !at_last, valid_q)
	`MLF_ASSERT_NOW(a_take_needs_drain, valid_q && can_take, spi.ready && at_last)

endmodule

FILE: rtl/memory_lcd_update_framer.sv
// ----------------------------------------------------------------------------
// memory_lcd_update_framer
// turns frame buffer bytes and clear / maintain commands into memory lcd bytes
// ----------------------------------------------------------------------------
//  channel  dir  payload                          word
//  req      in   req_type, pixel_byte             one request
//  spi      out  spi_byte, transfer_end, last     one wire-order byte
//
//  a request is decoded in the cycle it is taken; its one to three bytes
//  (five with single-byte lines) sit in a list register and leave one a cycle
//  a new request is taken in the cycle the last byte of the held list leaves,
//  or while the list register is empty; one that makes no bytes is dropped
//  reset clears vcom, line and byte counters and empties the list register
//  a stall on spi holds the current byte and, once the list is full, req
//  the list register is the only buffer between the two sides
// ----------------------------------------------------------------------------
module memory_lcd_update_framer (
	input  logic       clk,
	input  logic       arst_n,
	mlf_req_if.sink    req,
	mlf_spi_if.source  spi
);

	mlf_pkg::word_list_t list;
	logic                can_take;
	logic                take;

	// request accepted when the list register is free or emptying this cycle
	assign req.ready = can_take;
	assign take      = req.valid && can_take;

	// frame position, vcom level and per-request byte list
	mlf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.req_type   (req.req_type),
		.pixel_byte (req.pixel_byte),
		.list       (list)
	);

	// unused request codes make an empty list and are simply dropped
	mlf_drain u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && (list.count != '0)),
		.list     (list),
		.can_take (can_take),
		.spi      (spi)
	);

endmodule
